### design/cbs_pkg.sv
`timescale 1ns / 1ps

package cbs_pkg;

  localparam int NUM_POINTS  = 256;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_BITS  = 32;
  localparam int POS_BITS    = 24;
  localparam int IDX_BITS    = 8;
  localparam int K_BITS      = POS_BITS - FRAC_BITS;
  localparam int W_BITS      = 19;
  localparam int BANKS       = 4;
  localparam int BANK_DEPTH  = NUM_POINTS / BANKS;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int POINT_BITS  = 3 * COORD_BITS;
  localparam int CQ_DEPTH    = 4;
  localparam int OQ_DEPTH    = 16;
  localparam int MIN_SEG     = 3;
  localparam int RECIP3      = 349526;
  localparam int RECIP_SHIFT = 20;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    ORD_VALUE  = 2'd0,
    ORD_FIRST  = 2'd1,
    ORD_SECOND = 2'd2,
    ORD_NONE   = 2'd3
  } order_t;

  typedef struct packed {
    logic                         is_write;
    logic [IDX_BITS-1:0]          point_index;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [K_BITS-1:0]            k;
    logic [FRAC_BITS-1:0]         u;
    order_t                       order;
    logic                         idx_err;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         idx_err;
  } result_t;

endpackage

### design/cbs_ram.sv
`timescale 1ns / 1ps

module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/cbs_front.sv
`timescale 1ns / 1ps

module cbs_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   op,
  input  logic [cbs_pkg::IDX_BITS-1:0]           point_index,
  input  logic signed [cbs_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [cbs_pkg::COORD_BITS-1:0]  point_y,
  input  logic signed [cbs_pkg::COORD_BITS-1:0]  point_z,
  input  logic [cbs_pkg::POS_BITS-1:0]           position,
  input  logic [1:0]                             derivative_order,
  output logic                                   cmd_valid,
  output cbs_pkg::cmd_t                          cmd,
  input  logic                                   take
);

  localparam int CQ_AW = $clog2(cbs_pkg::CQ_DEPTH);
  localparam int CQ_CW = CQ_AW + 1;

  cbs_pkg::cmd_t    q [cbs_pkg::CQ_DEPTH];
  cbs_pkg::cmd_t    entry;
  logic [CQ_AW-1:0] wptr;
  logic [CQ_AW-1:0] rptr;
  logic [CQ_CW-1:0] cnt;
  logic             accept;

  assign full      = (cnt == CQ_CW'(cbs_pkg::CQ_DEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rptr];

  always_comb begin
    entry.is_write    = (op == cbs_pkg::OP_STORE);
    entry.point_index = point_index;
    entry.x           = point_x;
    entry.y           = point_y;
    entry.z           = point_z;
    entry.k           = position[cbs_pkg::POS_BITS-1:cbs_pkg::FRAC_BITS];
    entry.u           = position[cbs_pkg::FRAC_BITS-1:0];
    entry.order       = cbs_pkg::order_t'(derivative_order);
    entry.idx_err     = (position[cbs_pkg::POS_BITS-1:cbs_pkg::FRAC_BITS] <
                         cbs_pkg::K_BITS'(cbs_pkg::MIN_SEG));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + CQ_CW'(accept) - CQ_CW'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wptr] <= entry;
    end
  end

endmodule

### design/cbs_back.sv
`timescale 1ns / 1ps

module cbs_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  input  cbs_pkg::cmd_t                          cmd,
  output logic                                   take,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [cbs_pkg::COORD_BITS-1:0]  out_x,
  output logic signed [cbs_pkg::COORD_BITS-1:0]  out_y,
  output logic signed [cbs_pkg::COORD_BITS-1:0]  out_z,
  output logic                                   index_error
);

  localparam int CB    = cbs_pkg::COORD_BITS;
  localparam int FB    = cbs_pkg::FRAC_BITS;
  localparam int WB    = cbs_pkg::W_BITS;
  localparam int PB    = CB + WB;
  localparam int SB    = PB + 2;
  localparam int OQ_AW = $clog2(cbs_pkg::OQ_DEPTH);
  localparam int OQ_CW = OQ_AW + 1;
  localparam int NB    = 3 * FB + 6;
  localparam int QB    = 18;
  localparam int RB    = QB + 19;
  localparam int EB    = 2 * FB + 4;

  // issue
  logic             issue_eval;
  logic [OQ_CW-1:0] reserved;
  logic             pop_ok;

  assign pop_ok     = pop && !empty;
  assign take       = cmd_valid && (cmd.is_write || (reserved != OQ_CW'(cbs_pkg::OQ_DEPTH)));
  assign issue_eval = take && !cmd.is_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + OQ_CW'(issue_eval) - OQ_CW'(pop_ok);
    end
  end

  // command carried through stages 1..5
  logic          cv [1:5];
  cbs_pkg::cmd_t c  [1:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= 5; s++) begin
        cv[s] <= 1'b0;
      end
    end else begin
      cv[1] <= take;
      for (int s = 2; s <= 5; s++) begin
        cv[s] <= cv[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    c[1] <= cmd;
    for (int s = 2; s <= 5; s++) begin
      c[s] <= c[s-1];
    end
  end

  // stage 1: squares
  logic [FB:0]     m0;
  logic [2*FB-1:0] uu1;
  logic [2*FB+1:0] mm1;
  logic [FB:0]     m1;

  assign m0 = {1'b1, {FB{1'b0}}} - {1'b0, cmd.u};

  always_ff @(posedge clk) begin
    uu1 <= cmd.u * cmd.u;
    mm1 <= m0 * m0;
    m1  <= m0;
  end

  // stage 2: cubes
  logic [3*FB-1:0] uuu2;
  logic [3*FB+2:0] mmm2;
  logic [2*FB-1:0] uu2;
  logic [2*FB+1:0] mm2;
  logic [FB:0]     m2;

  always_ff @(posedge clk) begin
    uuu2 <= uu1 * c[1].u;
    mmm2 <= mm1 * m1;
    uu2  <= uu1;
    mm2  <= mm1;
    m2   <= m1;
  end

  // stage 3: weight numerators
  logic [QB-1:0]        q3 [3];
  logic signed [WB-1:0] a3 [3];

  always_comb begin
    logic signed [NB-1:0] uuu_s, uu_s, u_s, mmm_s, n0, n1, n2;
    logic signed [EB-1:0] uu_e, u_e, mm_e, e0, e1, e2;
    logic signed [WB-1:0] u_w, m_w;
    uuu_s = $signed({{(NB-3*FB){1'b0}}, uuu2});
    uu_s  = $signed({{(NB-2*FB){1'b0}}, uu2});
    u_s   = $signed({{(NB-FB){1'b0}}, c[2].u});
    mmm_s = $signed({{(NB-3*FB-3){1'b0}}, mmm2});
    n0 = mmm_s + (NB'(3) <<< (2*FB));
    n1 = NB'(3) * uuu_s - ((NB'(6) * uu_s) <<< FB) + (NB'(4) <<< (3*FB))
         + (NB'(3) <<< (2*FB));
    n2 = ((NB'(3) * uu_s) <<< FB) + ((NB'(3) * u_s) <<< (2*FB))
         + (NB'(1) <<< (3*FB)) - NB'(3) * uuu_s + (NB'(3) <<< (2*FB));
    uu_e = $signed({{(EB-2*FB){1'b0}}, uu2});
    u_e  = $signed({{(EB-FB){1'b0}}, c[2].u});
    mm_e = $signed({{(EB-2*FB-2){1'b0}}, mm2});
    e0 = (EB'(1) <<< FB) - mm_e;
    e1 = EB'(3) * uu_e - (u_e <<< (FB + 2)) + (EB'(1) <<< FB);
    e2 = (u_e <<< (FB + 1)) + (EB'(1) <<< (2*FB)) - EB'(3) * uu_e + (EB'(1) <<< FB);
    e0 = e0 >>> (FB + 1);
    e1 = e1 >>> (FB + 1);
    e2 = e2 >>> (FB + 1);
    u_w = $signed({{(WB-FB){1'b0}}, c[2].u});
    m_w = $signed({{(WB-FB-1){1'b0}}, m2});
    q3[0] = n0[2*FB+QB:2*FB+1];
    q3[1] = n1[2*FB+QB:2*FB+1];
    q3[2] = n2[2*FB+QB:2*FB+1];
    if (c[2].order == cbs_pkg::ORD_FIRST) begin
      a3[0] = e0[WB-1:0];
      a3[1] = e1[WB-1:0];
      a3[2] = e2[WB-1:0];
    end else begin
      a3[0] = m_w;
      a3[1] = WB'(3) * u_w - (WB'(1) <<< (FB + 1));
      a3[2] = (WB'(1) <<< FB) - WB'(3) * u_w;
    end
  end

  logic [QB-1:0]        q3r [3];
  logic signed [WB-1:0] a3r [3];

  always_ff @(posedge clk) begin
    q3r <= q3;
    a3r <= a3;
  end

  // stage 4: divide by three
  logic [RB-1:0]        p4 [3];
  logic signed [WB-1:0] a4 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p4[i] <= q3r[i] * 19'(cbs_pkg::RECIP3);
    end
    a4 <= a3r;
  end

  // stage 5: three weights, point store access
  logic signed [WB-1:0] w5 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (c[4].order == cbs_pkg::ORD_VALUE) begin
        w5[i] <= $signed({2'b0, p4[i][cbs_pkg::RECIP_SHIFT+WB-3:cbs_pkg::RECIP_SHIFT]});
      end else begin
        w5[i] <= a4[i];
      end
    end
  end

  logic [cbs_pkg::K_BITS-1:0]  base5;
  logic [cbs_pkg::BANK_AW-1:0] raddr [cbs_pkg::BANKS];
  logic [cbs_pkg::POINT_BITS-1:0] rdata [cbs_pkg::BANKS];
  logic [cbs_pkg::BANKS-1:0]   bank_we;

  always_comb begin
    logic [1:0]                 off;
    logic [cbs_pkg::K_BITS-1:0] j;
    base5 = c[5].k - cbs_pkg::K_BITS'(cbs_pkg::MIN_SEG);
    for (int b = 0; b < cbs_pkg::BANKS; b++) begin
      off      = 2'(b) - base5[1:0];
      j        = base5 + {{(cbs_pkg::K_BITS-2){1'b0}}, off};
      raddr[b] = j[cbs_pkg::K_BITS-1:2];
      bank_we[b] = cv[5] && c[5].is_write && (c[5].point_index[1:0] == 2'(b));
    end
  end

  for (genvar b = 0; b < cbs_pkg::BANKS; b++) begin : g_bank
    cbs_ram #(
      .WIDTH (cbs_pkg::POINT_BITS),
      .DEPTH (cbs_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (c[5].point_index[cbs_pkg::IDX_BITS-1:2]),
      .wdata ({c[5].x, c[5].y, c[5].z}),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  // stage 6: fourth weight
  logic                 v6, v7, v8;
  logic signed [WB-1:0] w6 [4];
  logic [1:0]           lo6;
  logic                 err6, err7, err8;
  logic                 none6, none7, none8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v6 <= cv[5] && !c[5].is_write;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    w6[0] <= w5[0];
    w6[1] <= w5[1];
    w6[2] <= w5[2];
    unique case (c[5].order)
      cbs_pkg::ORD_VALUE:  w6[3] <= (WB'(1) <<< FB) - w5[0] - w5[1] - w5[2];
      cbs_pkg::ORD_FIRST:  w6[3] <= -(w5[0] + w5[1] + w5[2]);
      default:             w6[3] <= $signed({{(WB-FB){1'b0}}, c[5].u});
    endcase
    lo6   <= base5[1:0];
    err6  <= c[5].idx_err;
    none6 <= (c[5].order == cbs_pkg::ORD_NONE);
  end

  // stage 7: products
  logic signed [PB-1:0] prod7 [3][4];

  always_ff @(posedge clk) begin
    logic [1:0]                 b;
    logic signed [CB-1:0]       pt [3];
    for (int i = 0; i < 4; i++) begin
      b     = lo6 + 2'(i);
      pt[0] = rdata[b][3*CB-1:2*CB];
      pt[1] = rdata[b][2*CB-1:CB];
      pt[2] = rdata[b][CB-1:0];
      for (int a = 0; a < 3; a++) begin
        prod7[a][i] <= pt[a] * w6[i];
      end
    end
    err7  <= err6;
    none7 <= none6;
  end

  // stage 8: sums
  logic signed [SB-1:0] sum8 [3];

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sum8[a] <= SB'(prod7[a][0]) + SB'(prod7[a][1]) + SB'(prod7[a][2])
                 + SB'(prod7[a][3]);
    end
    err8  <= err7;
    none8 <= none7;
  end

  // round, saturate, queue
  cbs_pkg::result_t res;

  always_comb begin
    logic signed [SB-1:0] r [3];
    logic signed [CB-1:0] sat [3];
    for (int a = 0; a < 3; a++) begin
      r[a] = (sum8[a] + (SB'(1) <<< (FB - 1))) >>> FB;
      if (r[a] > $signed(SB'({1'b0, {(CB-1){1'b1}}}))) begin
        sat[a] = {1'b0, {(CB-1){1'b1}}};
      end else if (r[a] < -$signed(SB'({1'b1, {(CB-1){1'b0}}}))) begin
        sat[a] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        sat[a] = r[a][CB-1:0];
      end
      if (err8 || none8) begin
        sat[a] = '0;
      end
    end
    res.x       = sat[0];
    res.y       = sat[1];
    res.z       = sat[2];
    res.idx_err = err8;
  end

  cbs_pkg::result_t oq [cbs_pkg::OQ_DEPTH];
  logic [OQ_AW-1:0] owp;
  logic [OQ_AW-1:0] orp;
  logic [OQ_CW-1:0] ocnt;

  assign empty       = (ocnt == '0);
  assign out_x       = oq[orp].x;
  assign out_y       = oq[orp].y;
  assign out_z       = oq[orp].z;
  assign index_error = oq[orp].idx_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (v8) begin
        owp <= owp + 1'b1;
      end
      if (pop_ok) begin
        orp <= orp + 1'b1;
      end
      ocnt <= ocnt + OQ_CW'(v8) - OQ_CW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (v8) begin
      oq[owp] <= res;
    end
  end

endmodule

### design/cubic_bspline_point_eval.sv
`timescale 1ns / 1ps

// Uniform cubic B-spline evaluator over 256 stored 3D control points (signed
// Q16.16). Store transactions write a point; evaluate transactions return the
// curve value or its first or second derivative at position k.u, blending
// points k-3..k, saturated to 32 bits, or zeros with index_error for k < 3
// (zeros also for derivative order 3). Sustained rate is one transaction
// per cycle while the output queue has room; an evaluate result passes the
// command queue and the arithmetic pipeline before the output queue. Points
// sit in four banks by index modulo four, so the four points of a segment
// are read in the same cycle. Up to sixteen results wait in the output queue;
// a stalled reader backs up into a four-entry command queue and then full.
module cubic_bspline_point_eval (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   op,
  input  logic [cbs_pkg::IDX_BITS-1:0]           point_index,
  input  logic signed [cbs_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [cbs_pkg::COORD_BITS-1:0]  point_y,
  input  logic signed [cbs_pkg::COORD_BITS-1:0]  point_z,
  input  logic [cbs_pkg::POS_BITS-1:0]           position,
  input  logic [1:0]                             derivative_order,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [cbs_pkg::COORD_BITS-1:0]  out_x,
  output logic signed [cbs_pkg::COORD_BITS-1:0]  out_y,
  output logic signed [cbs_pkg::COORD_BITS-1:0]  out_z,
  output logic                                   index_error
);

  logic          cmd_valid;
  logic          take;
  cbs_pkg::cmd_t cmd;

  cbs_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .op               (op),
    .point_index      (point_index),
    .point_x          (point_x),
    .point_y          (point_y),
    .point_z          (point_z),
    .position         (position),
    .derivative_order (derivative_order),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .take             (take)
  );

  cbs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .index_error (index_error)
  );

endmodule
